FILE: rtl/mfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_pkg
// Shared codes, frame constants, CRC-16/Modbus helper and handoff types for
// the Modbus RTU float read transaction block.
// ----------------------------------------------------------------------------
package mfr_pkg;

  // request opcodes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // result kinds
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // read status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_CRC   = 2'd2;

  // frame constants
  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam logic [7:0]  COUNT_HI        = 8'h00;
  localparam logic [7:0]  COUNT_LO        = 8'h02;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [2:0]  CRC_BYTES       = 3'd6;

  // receive byte positions
  localparam logic [3:0] RX_CRC_END   = 4'd7;
  localparam logic [3:0] RX_VAL_FIRST = 4'd3;
  localparam logic [3:0] RX_VAL_LAST  = 4'd6;
  localparam logic [3:0] RX_CRC_LO    = 4'd7;
  localparam logic [3:0] RX_CRC_HI    = 4'd8;
  localparam logic [3:0] RX_COUNT_MAX = 4'd15;

  // nibble table for the reflected 0xA001 polynomial
  localparam logic [15:0] NIB_TABLE [16] = '{
    16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
    16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
  };

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic [3:0]  n;
    n = crc[3:0] ^ b[3:0];
    c = {4'h0, crc[15:4]} ^ NIB_TABLE[n];
    n = c[3:0] ^ b[7:4];
    c = {4'h0, c[15:4]} ^ NIB_TABLE[n];
    return c;
  endfunction

  // frame generator load request
  typedef struct packed {
    logic        start;
    logic [7:0]  slave_address;
    logic [15:0] reg_address;
  } frame_load_t;

  // frame generator output beat
  typedef struct packed {
    logic       busy;
    logic       last;
    logic [7:0] tx_byte;
  } frame_beat_t;

endpackage

FILE: rtl/mfr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_req_if
// Request channel: start, received byte or timeout beats.
// ----------------------------------------------------------------------------
interface mfr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] reg_address;
  logic [7:0]  rx_byte;

  modport source(output valid, output op, output reg_address, output rx_byte,
                 input ready);
  modport sink(input valid, input op, input reg_address, input rx_byte,
               output ready);
endinterface

FILE: rtl/mfr_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_res_if
// Result channel: transmit bytes of the request frame and read results.
// ----------------------------------------------------------------------------
interface mfr_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [1:0]  status;
  logic [31:0] read_value;

  modport source(output valid, output kind, output tx_byte, output last,
                 output status, output read_value, input ready);
  modport sink(input valid, input kind, input tx_byte, input last,
               input status, input read_value, output ready);
endinterface

FILE: rtl/mfr_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_cfg_if
// Configuration write channel for the slave address register.
// ----------------------------------------------------------------------------
interface mfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] slave_address;

  modport source(output valid, output slave_address, input ready);
  modport sink(input valid, input slave_address, output ready);
endinterface

FILE: rtl/mfr_frame_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_frame_gen
// Steps through the eight request frame bytes, one per emit, folding each
// header byte into the CRC so the trailer is ready at byte six.
// ----------------------------------------------------------------------------
module mfr_frame_gen (
  input  logic                 clk,
  input  logic                 rst,
  input  mfr_pkg::frame_load_t load,
  input  logic                 emit,
  output mfr_pkg::frame_beat_t beat
);

  logic        busy;
  logic [2:0]  idx;
  logic [15:0] crc;
  logic [7:0]  slave;
  logic [15:0] addr;
  logic [7:0]  cur_byte;

  always_comb begin
    unique case (idx)
      3'd0: cur_byte = slave;
      3'd1: cur_byte = mfr_pkg::FUNC_READ_INPUT;
      3'd2: cur_byte = addr[15:8];
      3'd3: cur_byte = addr[7:0];
      3'd4: cur_byte = mfr_pkg::COUNT_HI;
      3'd5: cur_byte = mfr_pkg::COUNT_LO;
      3'd6: cur_byte = crc[7:0];
      3'd7: cur_byte = crc[15:8];
      default: cur_byte = '0;
    endcase
  end

  assign beat.busy    = busy;
  assign beat.last    = (idx == 3'd7);
  assign beat.tx_byte = cur_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      crc  <= mfr_pkg::CRC_INIT;
    end else if (load.start) begin
      busy  <= 1'b1;
      idx   <= '0;
      crc   <= mfr_pkg::CRC_INIT;
      slave <= load.slave_address;
      addr  <= load.reg_address;
    end else if (busy && emit) begin
      if (idx < mfr_pkg::CRC_BYTES) begin
        crc <= mfr_pkg::crc_byte(crc, cur_byte);
      end
      // drop busy after the trailer high byte
      if (idx == 3'd7) begin
        busy <= 1'b0;
      end
      idx <= idx + 3'd1;
    end
  end

endmodule

FILE: rtl/modbus_float_read_transaction_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_float_read_transaction_top
// Modbus RTU master for one read of two input registers returning float bits.
// ----------------------------------------------------------------------------
// Path: a byte or timeout result passes the stage register, then the output
// register to res; a start's first frame byte also passes the frame generator.
// Throughput: one byte or timeout beat per cycle while res takes results; after
// a start the beat behind it waits while the frame generator sends its eight
// bytes, longer when res stalls.
// Reset: synchronous rst clears all control, slave address returns to 1 and
// the block is idle, not awaiting a reply.
module modbus_float_read_transaction_top (
  input logic       clk,
  input logic       rst,
  mfr_req_if.sink   req,
  mfr_res_if.source res,
  mfr_cfg_if.sink   cfg
);

  // configuration
  logic [7:0] slave_address;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
    end else if (cfg.valid) begin
      slave_address <= cfg.slave_address;
    end
  end

  // request stage register
  logic        stg_valid;
  logic [1:0]  stg_op;
  logic [15:0] stg_addr;
  logic [7:0]  stg_byte;
  logic        stg_adv;

  // output register
  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_tx;
  logic        out_last;
  logic [1:0]  out_status;
  logic [31:0] out_value;
  logic        out_free;

  // frame generator
  mfr_pkg::frame_load_t fg_load;
  mfr_pkg::frame_beat_t fg_beat;
  logic                 fg_emit;

  assign out_free = !out_valid || res.ready;
  assign fg_emit  = fg_beat.busy && out_free;
  assign stg_adv  = stg_valid && !fg_beat.busy &&
                    (stg_op == mfr_pkg::OP_START || out_free);
  assign req.ready = !stg_valid || stg_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (req.ready) begin
      stg_valid <= req.valid;
      stg_op    <= req.op;
      stg_addr  <= req.reg_address;
      stg_byte  <= req.rx_byte;
    end
  end

  assign fg_load.start         = stg_adv && (stg_op == mfr_pkg::OP_START);
  assign fg_load.slave_address = slave_address;
  assign fg_load.reg_address   = stg_addr;

  mfr_frame_gen u_frame_gen (
    .clk  (clk),
    .rst  (rst),
    .load (fg_load),
    .emit (fg_emit),
    .beat (fg_beat)
  );

  // receive side state
  logic [3:0]  rx_count;
  logic [15:0] running_crc;
  logic [31:0] value_shift;
  logic [7:0]  crc_low;
  logic        awaiting;

  logic [3:0]  rx_count_next;
  logic [15:0] running_crc_next;
  logic [31:0] value_shift_next;
  logic [7:0]  crc_low_next;
  logic        awaiting_next;
  logic        rd_valid;
  logic [1:0]  rd_status;
  logic [31:0] rd_value;

  always_comb begin
    rx_count_next    = rx_count;
    running_crc_next = running_crc;
    value_shift_next = value_shift;
    crc_low_next     = crc_low;
    awaiting_next    = awaiting;
    rd_valid         = 1'b0;
    rd_status        = mfr_pkg::ST_OK;
    rd_value         = '0;
    if (stg_adv) begin
      unique case (stg_op)
        mfr_pkg::OP_START: begin
          rx_count_next    = '0;
          running_crc_next = mfr_pkg::CRC_INIT;
          value_shift_next = '0;
          crc_low_next     = '0;
          awaiting_next    = 1'b1;
        end
        mfr_pkg::OP_BYTE: begin
          if (awaiting) begin
            if (rx_count < mfr_pkg::RX_COUNT_MAX) begin
              rx_count_next = rx_count + 4'd1;
            end
            if (rx_count < mfr_pkg::RX_CRC_END) begin
              running_crc_next = mfr_pkg::crc_byte(running_crc, stg_byte);
            end
            if (rx_count >= mfr_pkg::RX_VAL_FIRST && rx_count <= mfr_pkg::RX_VAL_LAST) begin
              value_shift_next = {value_shift[23:0], stg_byte};
            end
            if (rx_count == mfr_pkg::RX_CRC_LO) begin
              crc_low_next = stg_byte;
            end
            if (rx_count == mfr_pkg::RX_CRC_HI) begin
              awaiting_next = 1'b0;
              rd_valid      = 1'b1;
              if ({stg_byte, crc_low} == running_crc) begin
                rd_status = mfr_pkg::ST_OK;
                rd_value  = value_shift;
              end else begin
                rd_status = mfr_pkg::ST_CRC;
              end
            end
          end
        end
        mfr_pkg::OP_TIMEOUT: begin
          if (awaiting) begin
            awaiting_next = 1'b0;
            rd_valid      = 1'b1;
            rd_status     = mfr_pkg::ST_SHORT;
          end
        end
        default: begin
          // unused opcode: hold everything
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count    <= '0;
      running_crc <= mfr_pkg::CRC_INIT;
      value_shift <= '0;
      crc_low     <= '0;
      awaiting    <= 1'b0;
    end else begin
      rx_count    <= rx_count_next;
      running_crc <= running_crc_next;
      value_shift <= value_shift_next;
      crc_low     <= crc_low_next;
      awaiting    <= awaiting_next;
    end
  end

  // output register: frame bytes take the slot while the generator runs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      if (fg_emit) begin
        out_valid  <= 1'b1;
        out_kind   <= mfr_pkg::KIND_TX;
        out_tx     <= fg_beat.tx_byte;
        out_last   <= fg_beat.last;
        out_status <= mfr_pkg::ST_OK;
        out_value  <= '0;
      end else if (rd_valid) begin
        out_valid  <= 1'b1;
        out_kind   <= mfr_pkg::KIND_READ;
        out_tx     <= '0;
        out_last   <= 1'b0;
        out_status <= rd_status;
        out_value  <= rd_value;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid      = out_valid;
  assign res.kind       = out_kind;
  assign res.tx_byte    = out_tx;
  assign res.last       = out_last;
  assign res.status     = out_status;
  assign res.read_value = out_value;

endmodule
